>>> design/cddd_pkg.sv
`timescale 1ns / 1ps
package cddd_pkg;

  localparam int YEAR_BITS  = 16;
  localparam int MONTH_BITS = 4;
  localparam int DAY_BITS   = 5;
  localparam int DIFF_BITS  = 26;

  localparam int DATE_BITS   = YEAR_BITS + MONTH_BITS + DAY_BITS;
  localparam int IN_BITS     = 2 * (YEAR_BITS + MONTH_BITS + DAY_BITS);
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = DIFF_BITS + 2 + 1 + 1;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // biased year and floor division by 400 through a reciprocal of 25
  localparam int UBITS       = YEAR_BITS + 1;
  localparam int XBITS       = YEAR_BITS - 3;
  localparam int RECIP_SHIFT = XBITS + 5;
  localparam int RBITS       = XBITS + 1;
  localparam int PBITS       = XBITS + RBITS;
  localparam int QBITS       = YEAR_BITS - 7;
  localparam int ERA_BITS    = YEAR_BITS - 6;
  localparam int YOE_BITS    = 9;
  localparam int DOY_BITS    = 9;
  localparam int DOE_BITS    = 18;
  localparam int DNUM_BITS   = YEAR_BITS + 10;
  localparam int WIDE_BITS   = (YEAR_BITS + 11 > DIFF_BITS + 1) ? YEAR_BITS + 11 : DIFF_BITS + 1;

  localparam int YEARS_PER_ERA = 400;
  localparam int DAYS_PER_YEAR = 365;
  localparam int DAYS_PER_ERA  = 146097;
  localparam int EPOCH_DAYS    = 719468;

  localparam logic [63:0] RECIP_25 = (64'd1 << RECIP_SHIFT) / 64'd25 + 64'd1;
  localparam longint ERA_BIAS = (longint'(1) << (YEAR_BITS - 1)) / YEARS_PER_ERA + 1;
  localparam logic [UBITS-1:0] YEAR_OFS = UBITS'(ERA_BIAS * YEARS_PER_ERA);

  localparam logic signed [WIDE_BITS-1:0] DIFF_MAX =
    WIDE_BITS'((longint'(1) << (DIFF_BITS - 1)) - 1);
  localparam logic signed [WIDE_BITS-1:0] DIFF_MIN =
    WIDE_BITS'(-(longint'(1) << (DIFF_BITS - 1)));

  localparam logic [MONTH_BITS-1:0] JANUARY  = 4'd1;
  localparam logic [MONTH_BITS-1:0] FEBRUARY = 4'd2;
  localparam logic [MONTH_BITS-1:0] DECEMBER = 4'd12;
  localparam logic [DAY_BITS-1:0]   LEAP_FEB_DAYS = 5'd29;

  typedef enum logic [1:0] {
    ORD_EARLIER = 2'd0,
    ORD_SAME    = 2'd1,
    ORD_LATER   = 2'd2
  } order_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } lane_en_t;

  typedef struct packed {
    logic diff;
    logic out;
  } merge_en_t;

  function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m);
    logic [DAY_BITS-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  // days from March 1 to the first of the month
  function automatic logic [DOY_BITS-1:0] march_offset(input logic [MONTH_BITS-1:0] m);
    logic [DOY_BITS-1:0] ofs;
    unique case (m)
      4'd3:    ofs = 9'd0;
      4'd4:    ofs = 9'd31;
      4'd5:    ofs = 9'd61;
      4'd6:    ofs = 9'd92;
      4'd7:    ofs = 9'd122;
      4'd8:    ofs = 9'd153;
      4'd9:    ofs = 9'd184;
      4'd10:   ofs = 9'd214;
      4'd11:   ofs = 9'd245;
      4'd12:   ofs = 9'd275;
      4'd1:    ofs = 9'd306;
      4'd2:    ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

>>> design/cddd_lane.sv
`timescale 1ns / 1ps
module cddd_lane (
  input  logic                                   clk,
  input  cddd_pkg::lane_en_t                     en,
  input  logic signed [cddd_pkg::YEAR_BITS-1:0]  year,
  input  logic [cddd_pkg::MONTH_BITS-1:0]        month,
  input  logic [cddd_pkg::DAY_BITS-1:0]          day,
  output logic signed [cddd_pkg::DNUM_BITS-1:0]  day_num,
  output logic                                   date_ok
);

  // stage 1: shift year to March base, bias, divide by 400
  logic                                   before_mar;
  logic signed [cddd_pkg::UBITS-1:0]      yp;
  logic [cddd_pkg::UBITS-1:0]             u_nxt;
  logic [cddd_pkg::XBITS-1:0]             x;
  logic [cddd_pkg::PBITS-1:0]             prod;
  logic [cddd_pkg::QBITS-1:0]             q_nxt;
  logic [cddd_pkg::DOY_BITS-1:0]          doy_nxt;
  logic                                   mok_nxt;

  logic [cddd_pkg::UBITS-1:0]             u_r;
  logic [cddd_pkg::QBITS-1:0]             q_r;
  logic [cddd_pkg::DOY_BITS-1:0]          doy_r;
  logic                                   feb_r;
  logic                                   mok_r;
  logic [cddd_pkg::DAY_BITS-1:0]          day_r;
  logic [cddd_pkg::DAY_BITS-1:0]          mlen_r;

  always_comb begin
    before_mar = (month <= cddd_pkg::FEBRUARY);
    yp         = cddd_pkg::UBITS'(year) - cddd_pkg::UBITS'(before_mar);
    u_nxt      = cddd_pkg::UBITS'(yp) + cddd_pkg::YEAR_OFS;
    x          = u_nxt[cddd_pkg::UBITS-1:4];
    prod       = cddd_pkg::PBITS'(x) * cddd_pkg::PBITS'(cddd_pkg::RECIP_25);
    q_nxt      = prod[cddd_pkg::RECIP_SHIFT +: cddd_pkg::QBITS];
    doy_nxt    = cddd_pkg::march_offset(month) + cddd_pkg::DOY_BITS'(day)
                 - cddd_pkg::DOY_BITS'(1);
    mok_nxt    = (month >= cddd_pkg::JANUARY) && (month <= cddd_pkg::DECEMBER);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      u_r    <= u_nxt;
      q_r    <= q_nxt;
      doy_r  <= doy_nxt;
      feb_r  <= (month == cddd_pkg::FEBRUARY);
      mok_r  <= mok_nxt;
      day_r  <= day;
      mlen_r <= cddd_pkg::month_len(month);
    end
  end

  // stage 2: year of era, era, day of era, leap check
  logic [cddd_pkg::UBITS-1:0]             yoe_full;
  logic [cddd_pkg::YOE_BITS-1:0]          yoe;
  logic [cddd_pkg::YOE_BITS-1:0]          yoe_n;
  logic [1:0]                             cent;
  logic                                   leap;
  logic [cddd_pkg::DAY_BITS-1:0]          mlen;
  logic signed [cddd_pkg::ERA_BITS-1:0]   era_nxt;
  logic [cddd_pkg::DOE_BITS-1:0]          doe_nxt;
  logic                                   ok_nxt;

  logic signed [cddd_pkg::ERA_BITS-1:0]   era_r;
  logic [cddd_pkg::DOE_BITS-1:0]          doe_r;
  logic                                   ok_r;

  always_comb begin
    yoe_full = u_r - cddd_pkg::UBITS'(cddd_pkg::UBITS'(q_r)
               * cddd_pkg::UBITS'(cddd_pkg::YEARS_PER_ERA));
    yoe      = yoe_full[cddd_pkg::YOE_BITS-1:0];
    era_nxt  = cddd_pkg::ERA_BITS'($signed({1'b0, q_r}))
               - cddd_pkg::ERA_BITS'(cddd_pkg::ERA_BIAS);
    if (yoe >= 9'd300) begin
      cent = 2'd3;
    end else if (yoe >= 9'd200) begin
      cent = 2'd2;
    end else if (yoe >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
    doe_nxt  = cddd_pkg::DOE_BITS'(yoe) * cddd_pkg::DOE_BITS'(cddd_pkg::DAYS_PER_YEAR)
               + cddd_pkg::DOE_BITS'(yoe >> 2) - cddd_pkg::DOE_BITS'(cent)
               + cddd_pkg::DOE_BITS'(doy_r);
    // calendar year of a February date is one past the March-based year
    yoe_n    = (yoe == 9'd399) ? 9'd0 : yoe + 9'd1;
    leap     = (yoe_n[1:0] == 2'd0)
               && ((yoe_n == 9'd0)
                   || !((yoe_n == 9'd100) || (yoe_n == 9'd200) || (yoe_n == 9'd300)));
    mlen     = (feb_r && leap) ? cddd_pkg::LEAP_FEB_DAYS : mlen_r;
    ok_nxt   = mok_r && (day_r != '0) && (day_r <= mlen);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      era_r <= era_nxt;
      doe_r <= doe_nxt;
      ok_r  <= ok_nxt;
    end
  end

  // stage 3: day number from the epoch
  logic signed [cddd_pkg::DNUM_BITS-1:0]  day_num_nxt;
  logic signed [cddd_pkg::DNUM_BITS-1:0]  day_num_r;
  logic                                   date_ok_r;

  always_comb begin
    day_num_nxt = cddd_pkg::DNUM_BITS'(era_r) * cddd_pkg::DNUM_BITS'(cddd_pkg::DAYS_PER_ERA)
                  + cddd_pkg::DNUM_BITS'($signed({1'b0, doe_r}))
                  - cddd_pkg::DNUM_BITS'(cddd_pkg::EPOCH_DAYS);
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      day_num_r <= day_num_nxt;
      date_ok_r <= ok_r;
    end
  end

  assign day_num = day_num_r;
  assign date_ok = date_ok_r;

endmodule

>>> design/cddd_merge.sv
`timescale 1ns / 1ps
module cddd_merge (
  input  logic                                   clk,
  input  cddd_pkg::merge_en_t                    en,
  input  logic signed [cddd_pkg::DNUM_BITS-1:0]  day_num_a,
  input  logic signed [cddd_pkg::DNUM_BITS-1:0]  day_num_b,
  input  logic                                   ok_a,
  input  logic                                   ok_b,
  output logic signed [cddd_pkg::DIFF_BITS-1:0]  days_between,
  output cddd_pkg::order_t                       order_code,
  output logic                                   first_valid,
  output logic                                   second_valid
);

  logic signed [cddd_pkg::WIDE_BITS-1:0]  diff_nxt;
  logic signed [cddd_pkg::WIDE_BITS-1:0]  diff_r;
  logic                                   va_r;
  logic                                   vb_r;

  always_comb begin
    diff_nxt = cddd_pkg::WIDE_BITS'(day_num_b) - cddd_pkg::WIDE_BITS'(day_num_a);
  end

  always_ff @(posedge clk) begin
    if (en.diff) begin
      diff_r <= diff_nxt;
      va_r   <= ok_a;
      vb_r   <= ok_b;
    end
  end

  logic signed [cddd_pkg::DIFF_BITS-1:0]  days_nxt;
  cddd_pkg::order_t                       order_nxt;
  logic signed [cddd_pkg::DIFF_BITS-1:0]  days_between_r;
  cddd_pkg::order_t                       order_code_r;
  logic                                   first_valid_r;
  logic                                   second_valid_r;

  always_comb begin
    days_nxt  = '0;
    order_nxt = cddd_pkg::ORD_EARLIER;
    if (va_r && vb_r) begin
      if (diff_r > cddd_pkg::DIFF_MAX) begin
        days_nxt = cddd_pkg::DIFF_BITS'(cddd_pkg::DIFF_MAX);
      end else if (diff_r < cddd_pkg::DIFF_MIN) begin
        days_nxt = cddd_pkg::DIFF_BITS'(cddd_pkg::DIFF_MIN);
      end else begin
        days_nxt = cddd_pkg::DIFF_BITS'(diff_r);
      end
      if (diff_r == '0) begin
        order_nxt = cddd_pkg::ORD_SAME;
      end else if (diff_r[cddd_pkg::WIDE_BITS-1]) begin
        order_nxt = cddd_pkg::ORD_LATER;
      end else begin
        order_nxt = cddd_pkg::ORD_EARLIER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.out) begin
      days_between_r <= days_nxt;
      order_code_r   <= order_nxt;
      first_valid_r  <= va_r;
      second_valid_r <= vb_r;
    end
  end

  assign days_between = days_between_r;
  assign order_code   = order_code_r;
  assign first_valid  = first_valid_r;
  assign second_valid = second_valid_r;

endmodule

>>> design/civil_date_day_difference_top.sv
`timescale 1ns / 1ps
// Signed day count between two proleptic Gregorian dates.
// Input channel in_*: one request carries two dates (year, month, day each).
// Output channel out_*: one result per request with the day difference
// (second minus first, saturated to 26 bits), an order code and one
// validity flag per date. Difference and order are zero when either date
// fails its month or day check.
// Each date lane registers the divide by 400, the day of era and the epoch
// multiply; the merge then registers the subtract and the output.
// Throughput: one request per cycle while out_tready is high; both dates
// are handled side by side in two lanes with no shared unit.
// Reset (rst_n low, synchronous) drops every request in flight and clears
// out_tvalid; no clearing pass is needed.
// When the receiver holds out_tready low the result stays on out_tdata;
// bubbles in the pipeline still fill, and in_tready falls only once all
// five stages hold a request.
module civil_date_day_difference_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // year_a, month_a, day_a, year_b, month_b, day_b, zero pad
  input  logic [cddd_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // days_between, order_code, first_valid, second_valid, zero pad
  output logic [cddd_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  logic signed [cddd_pkg::YEAR_BITS-1:0]  year_a;
  logic [cddd_pkg::MONTH_BITS-1:0]        month_a;
  logic [cddd_pkg::DAY_BITS-1:0]          day_a;
  logic signed [cddd_pkg::YEAR_BITS-1:0]  year_b;
  logic [cddd_pkg::MONTH_BITS-1:0]        month_b;
  logic [cddd_pkg::DAY_BITS-1:0]          day_b;

  assign year_a  = in_tdata[0 +: cddd_pkg::YEAR_BITS];
  assign month_a = in_tdata[cddd_pkg::YEAR_BITS +: cddd_pkg::MONTH_BITS];
  assign day_a   = in_tdata[cddd_pkg::YEAR_BITS + cddd_pkg::MONTH_BITS +: cddd_pkg::DAY_BITS];
  assign year_b  = in_tdata[cddd_pkg::DATE_BITS +: cddd_pkg::YEAR_BITS];
  assign month_b = in_tdata[cddd_pkg::DATE_BITS + cddd_pkg::YEAR_BITS +: cddd_pkg::MONTH_BITS];
  assign day_b   = in_tdata[cddd_pkg::DATE_BITS + cddd_pkg::YEAR_BITS + cddd_pkg::MONTH_BITS +:
                            cddd_pkg::DAY_BITS];

  // pipeline occupancy and stage advance
  logic [4:0] v_r;
  logic [4:0] v_nxt;
  logic [4:0] adv;
  logic [4:0] load;

  always_comb begin
    adv[4]  = !v_r[4] || out_tready;
    adv[3]  = !v_r[3] || adv[4];
    adv[2]  = !v_r[2] || adv[3];
    adv[1]  = !v_r[1] || adv[2];
    adv[0]  = !v_r[0] || adv[1];
    load[0] = adv[0] && in_tvalid;
    load[1] = adv[1] && v_r[0];
    load[2] = adv[2] && v_r[1];
    load[3] = adv[3] && v_r[2];
    load[4] = adv[4] && v_r[3];
    v_nxt[0] = adv[0] ? in_tvalid : v_r[0];
    v_nxt[1] = adv[1] ? v_r[0]    : v_r[1];
    v_nxt[2] = adv[2] ? v_r[1]    : v_r[2];
    v_nxt[3] = adv[3] ? v_r[2]    : v_r[3];
    v_nxt[4] = adv[4] ? v_r[3]    : v_r[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  cddd_pkg::lane_en_t   lane_en;
  cddd_pkg::merge_en_t  merge_en;

  assign lane_en.s1    = load[0];
  assign lane_en.s2    = load[1];
  assign lane_en.s3    = load[2];
  assign merge_en.diff = load[3];
  assign merge_en.out  = load[4];

  logic signed [cddd_pkg::DNUM_BITS-1:0]  day_num_a;
  logic signed [cddd_pkg::DNUM_BITS-1:0]  day_num_b;
  logic                                   ok_a;
  logic                                   ok_b;

  cddd_lane u_lane_a (
    .clk     (clk),
    .en      (lane_en),
    .year    (year_a),
    .month   (month_a),
    .day     (day_a),
    .day_num (day_num_a),
    .date_ok (ok_a)
  );

  cddd_lane u_lane_b (
    .clk     (clk),
    .en      (lane_en),
    .year    (year_b),
    .month   (month_b),
    .day     (day_b),
    .day_num (day_num_b),
    .date_ok (ok_b)
  );

  logic signed [cddd_pkg::DIFF_BITS-1:0]  days_between;
  cddd_pkg::order_t                       order_code;
  logic                                   first_valid;
  logic                                   second_valid;

  cddd_merge u_merge (
    .clk          (clk),
    .en           (merge_en),
    .day_num_a    (day_num_a),
    .day_num_b    (day_num_b),
    .ok_a         (ok_a),
    .ok_b         (ok_b),
    .days_between (days_between),
    .order_code   (order_code),
    .first_valid  (first_valid),
    .second_valid (second_valid)
  );

  assign in_tready  = adv[0];
  assign out_tvalid = v_r[4];
  assign out_tdata  = cddd_pkg::OUT_TDATA_W'({second_valid, first_valid,
                                             2'(order_code), days_between});

  a_stall_only_at_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while pipeline has room");

  a_same_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && order_code == cddd_pkg::ORD_SAME) |-> (days_between == '0))
    else $error("same-day result with nonzero difference");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !(first_valid && second_valid))
      |-> (days_between == '0 && order_code == cddd_pkg::ORD_EARLIER))
    else $error("invalid date pair with nonzero result");

  a_order_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && first_valid && second_valid && order_code == cddd_pkg::ORD_EARLIER)
      |-> (!days_between[cddd_pkg::DIFF_BITS-1] && days_between != '0))
    else $error("order code disagrees with sign of difference");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic [cddd_pkg::DAY_BITS-1:0]   day;
    logic [cddd_pkg::MONTH_BITS-1:0] month;
    logic [cddd_pkg::YEAR_BITS-1:0]  year;
  } date_t;

  typedef struct packed {
    logic signed [cddd_pkg::DIFF_BITS-1:0] days;
    cddd_pkg::order_t                      order;
    logic                                  first_ok;
    logic                                  second_ok;
  } span_t;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 634;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // year_a, month_a, day_a, year_b, month_b, day_b, zero pad
  logic [cddd_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // days_between, order_code, first_valid, second_valid, zero pad
  logic [cddd_pkg::OUT_TDATA_W-1:0] out_tdata;

  logic [cddd_pkg::IN_TDATA_W-1:0] pending_q[$];
  span_t span_q[$];
  int send_idle = 26;
  int recv_idle = 53;
  int mismatches = 0;
  int pairs_sent = 0;
  int pairs_both_valid = 0;
  int directed_count = 0;
  int idle_cycles = 0;
  span_t want;
  span_t got;

  wire in_fire  = in_tvalid & in_tready;
  wire out_fire = out_tvalid & out_tready;

  civil_date_day_difference_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic bit leap_year(longint yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int days_in_month(longint yr, int mo);
    int len;
    case (mo)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = leap_year(yr) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  function automatic bit date_valid(longint yr, int mo, int dy);
    if (mo < 1 || mo > 12) return 1'b0;
    return (dy >= 1) && (dy <= days_in_month(yr, mo));
  endfunction

  function automatic longint epoch_day(longint yr, int mo, int dy);
    longint y;
    longint era;
    longint yoe;
    longint mp;
    longint doy;
    longint doe;
    y = (mo <= 2) ? yr - 1 : yr;
    era = ((y >= 0) ? y : y - 399) / 400;
    yoe = y - era * 400;
    mp = (mo > 2) ? mo - 3 : mo + 9;
    doy = (153 * mp + 2) / 5 + dy - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic span_t predict_span(logic [cddd_pkg::IN_TDATA_W-1:0] req);
    date_t a;
    date_t b;
    longint ya;
    longint yb;
    longint delta;
    longint hi;
    longint lo;
    span_t s;
    {b, a} = req[2*$bits(date_t)-1:0];
    ya = longint'($signed(a.year));
    yb = longint'($signed(b.year));
    hi = (longint'(1) << (cddd_pkg::DIFF_BITS - 1)) - 1;
    lo = -(longint'(1) << (cddd_pkg::DIFF_BITS - 1));
    s.first_ok = date_valid(ya, int'(a.month), int'(a.day));
    s.second_ok = date_valid(yb, int'(b.month), int'(b.day));
    s.days = '0;
    s.order = cddd_pkg::ORD_EARLIER;
    if (s.first_ok && s.second_ok) begin
      delta = epoch_day(yb, int'(b.month), int'(b.day)) -
              epoch_day(ya, int'(a.month), int'(a.day));
      s.order = (delta > 0) ? cddd_pkg::ORD_EARLIER :
                ((delta == 0) ? cddd_pkg::ORD_SAME : cddd_pkg::ORD_LATER);
      if (delta > hi)
        delta = hi;
      if (delta < lo)
        delta = lo;
      s.days = cddd_pkg::DIFF_BITS'(delta);
    end
    return s;
  endfunction

  function automatic date_t mk_date(int y, int m, int d);
    date_t r;
    r.year = cddd_pkg::YEAR_BITS'(y);
    r.month = cddd_pkg::MONTH_BITS'(m);
    r.day = cddd_pkg::DAY_BITS'(d);
    return r;
  endfunction

  function automatic date_t random_date();
    logic signed [cddd_pkg::YEAR_BITS-1:0] yr;
    int y;
    int m;
    int len;
    int sel;
    sel = $urandom_range(9);
    yr = cddd_pkg::YEAR_BITS'($urandom);
    if (sel < 4) y = int'(yr);
    else if (sel < 8) y = int'($urandom_range(2600)) - 600;
    else if (sel == 8) y = 32767 - int'($urandom_range(3));
    else y = -32768 + int'($urandom_range(3));
    m = $urandom_range(12, 1);
    len = days_in_month(y, m);
    return mk_date(y, m, ($urandom_range(3) == 0) ? len : $urandom_range(len, 1));
  endfunction

  function automatic date_t noise_date();
    logic [31:0] r;
    r = $urandom;
    return r[$bits(date_t)-1:0];
  endfunction

  task automatic push_pair(date_t a, date_t b);
    pending_q.push_back(cddd_pkg::IN_TDATA_W'({b, a}));
  endtask

  task automatic push_directed();
    push_pair(mk_date(1970, 1, 1), mk_date(1970, 1, 1));
    push_pair(mk_date(1970, 1, 1), mk_date(2000, 3, 1));
    push_pair(mk_date(2024, 2, 29), mk_date(2023, 2, 28));
    push_pair(mk_date(2000, 2, 29), mk_date(1900, 2, 29));
    push_pair(mk_date(1900, 2, 29), mk_date(1999, 12, 31));
    push_pair(mk_date(2010, 0, 10), mk_date(2010, 5, 10));
    push_pair(mk_date(2010, 6, 10), mk_date(2010, 13, 10));
    push_pair(mk_date(1234, 15, 31), mk_date(4321, 15, 31));
    push_pair(mk_date(1999, 7, 0), mk_date(1999, 7, 31));
    push_pair(mk_date(2001, 4, 31), mk_date(2001, 12, 31));
    push_pair(mk_date(-32768, 1, 1), mk_date(32767, 12, 31));
    push_pair(mk_date(32767, 12, 31), mk_date(-32768, 1, 1));
    push_pair(mk_date(0, 2, 29), mk_date(-1, 12, 31));
    push_pair(mk_date(-400, 3, 1), mk_date(-401, 2, 28));
    push_pair(mk_date(-100, 2, 29), mk_date(0, 1, 1));
    push_pair(mk_date(-4, 2, 29), mk_date(4, 2, 29));
    push_pair(mk_date(1600, 2, 29), mk_date(1700, 3, 1));
    push_pair(mk_date(-1, 12, 31), mk_date(0, 1, 1));
    push_pair(mk_date(-32768, 14, 0), mk_date(32767, 0, 31));
    push_pair(mk_date(2024, 2, 30), mk_date(-32768, 2, 29));
    push_pair(mk_date(32767, 1, 31), mk_date(-32768, 3, 1));
    directed_count = 21;
  endtask

  task automatic push_random(int count);
    date_t a;
    date_t b;
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      a = random_date();
      b = random_date();
      if (kind < 55) begin
      end else if (kind < 65) begin
        b = a;
      end else if (kind < 75) begin
        b.year = a.year + cddd_pkg::YEAR_BITS'($urandom_range(6)) - cddd_pkg::YEAR_BITS'(3);
      end else if (kind < 85) begin
        if ($urandom_range(1)) a = noise_date();
        else b = noise_date();
      end else begin
        a = noise_date();
        b = noise_date();
      end
      push_pair(a, b);
    end
  endtask

  // hold until every pending request is sent and every result is back
  task automatic drain();
    while (pending_q.size() != 0 || in_tvalid || span_q.size() != 0)
      @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_tdata <= pending_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle);
    if (rst_n) begin
      if (in_fire) begin
        want = predict_span(in_tdata);
        span_q.push_back(want);
        pairs_sent++;
        if (want.first_ok && want.second_ok) pairs_both_valid++;
      end
      if (out_fire) begin
        got.days = out_tdata[cddd_pkg::DIFF_BITS-1:0];
        got.order = cddd_pkg::order_t'(out_tdata[cddd_pkg::DIFF_BITS+1:cddd_pkg::DIFF_BITS]);
        got.first_ok = out_tdata[cddd_pkg::DIFF_BITS+2];
        got.second_ok = out_tdata[cddd_pkg::DIFF_BITS+3];
        if (span_q.size() == 0) begin
          $error("unexpected result: out_tdata %h", out_tdata);
          mismatches++;
        end else begin
          want = span_q.pop_front();
          if (got.days !== want.days) begin
            $error("days_between: expected %0d, got %0d", want.days, got.days);
            mismatches++;
          end
          if (got.order !== want.order) begin
            $error("order_code: expected %0d, got %0d", want.order, got.order);
            mismatches++;
          end
          if (got.first_ok !== want.first_ok) begin
            $error("first_valid: expected %0b, got %0b", want.first_ok, got.first_ok);
            mismatches++;
          end
          if (got.second_ok !== want.second_ok) begin
            $error("second_valid: expected %0b, got %0b", want.second_ok, got.second_ok);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || in_fire || out_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    push_directed();
    push_random(PHASE_ITEMS);
    drain();
    send_idle = 53;
    recv_idle = 26;
    push_random(PHASE_ITEMS);
    drain();
    send_idle = 0;
    recv_idle = 0;
    push_random(PHASE_ITEMS);
    drain();
    repeat (12) @(posedge clk);
    $display("Ran %0d date pairs (%0d directed), %0d with both dates valid,",
             pairs_sent, directed_count, pairs_both_valid);
    $display("under sender stalls, receiver stalls and full-rate streaming.");
    if (mismatches == 0 && span_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/cddd_pkg.sv
design/cddd_lane.sv
design/cddd_merge.sv
design/civil_date_day_difference_top.sv
dv/tb.sv
